### rtl/core/dtfp_pkg.sv
// ----------------------------------------------------------------------------
// dtfp_pkg
// Shared types, constants and the pow10 function for the ascii decimal to fixed-point core.
// ----------------------------------------------------------------------------
package dtfp_pkg;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // field widths
  localparam int unsigned CH_W    = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned FRAC_W  = 3;

  // parser phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LEAD = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  // accumulated number handed from the parser to the scaler
  typedef struct packed {
    logic [VALUE_W-1:0] accum;
    logic [FRAC_W-1:0]  digits_left;
    logic               neg;
    logic               found;
  } num_t;

  // ten to the power k, wrapped to the value width
  function automatic logic [VALUE_W-1:0] pow10(input logic [FRAC_W-1:0] k);
    logic [VALUE_W-1:0] p;
    begin
      unique case (k)
        3'd0: p = 16'd1;
        3'd1: p = 16'd10;
        3'd2: p = 16'd100;
        3'd3: p = 16'd1000;
        3'd4: p = 16'd10000;
        3'd5: p = 16'd34464;
        3'd6: p = 16'd16960;
        3'd7: p = 16'd38528;
        default: p = 16'd1;
      endcase
      return p;
    end
  endfunction

endpackage

### rtl/core/dtfp_parse.sv
// ----------------------------------------------------------------------------
// dtfp_parse
// Character parser: phase, accumulator, sign, point, count and found state.
// ----------------------------------------------------------------------------
module dtfp_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,   // item taken this cycle
  input  logic                          item_vld,  // an item is held
  input  logic [dtfp_pkg::CH_W-1:0]     ch,
  input  logic                          start,
  input  logic [dtfp_pkg::FRAC_W-1:0]   frac_digits,
  output logic                          term,      // item ends a number
  output dtfp_pkg::num_t                num,
  output logic [dtfp_pkg::COUNT_W-1:0]  consumed
);
  import dtfp_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [VALUE_W-1:0] accum_r, accum_nxt;
  logic               neg_r, neg_nxt;
  logic               point_r, point_nxt;
  logic [FRAC_W-1:0]  dl_r, dl_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               found_r, found_nxt;

  // state seen by this item after a possible restart
  phase_t             ph_e;
  logic [VALUE_W-1:0] accum_e;
  logic               neg_e, point_e, found_e;
  logic [FRAC_W-1:0]  dl_e;
  logic [COUNT_W-1:0] cnt_e;
  logic               is_digit, fits;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

  // restart on start, else carry on
  always_comb begin
    if (start) begin
      ph_e    = PH_LEAD;
      accum_e = '0;
      neg_e   = 1'b0;
      point_e = 1'b0;
      dl_e    = frac_digits;
      cnt_e   = '0;
      found_e = 1'b0;
    end else begin
      ph_e    = phase_r;
      accum_e = accum_r;
      neg_e   = neg_r;
      point_e = point_r;
      dl_e    = dl_r;
      cnt_e   = cnt_r;
      found_e = found_r;
    end
  end

  assign fits = is_digit || ((ch == CH_POINT) && !point_e);

  // next state and end-of-number detect
  always_comb begin
    phase_nxt = ph_e;
    accum_nxt = accum_e;
    neg_nxt   = neg_e;
    point_nxt = point_e;
    dl_nxt    = dl_e;
    cnt_nxt   = cnt_e;
    found_nxt = found_e;
    term      = 1'b0;
    unique case (ph_e)
      PH_IDLE: begin
      end
      PH_LEAD: begin
        if (ch == CH_SPACE) begin
          cnt_nxt = cnt_e + 1'b1;
        end else if (ch == CH_MINUS) begin
          phase_nxt = PH_BODY;
          neg_nxt   = 1'b1;
          cnt_nxt   = cnt_e + 1'b1;
        end else if (fits) begin
          phase_nxt = PH_BODY;
          cnt_nxt   = cnt_e + 1'b1;
          found_nxt = 1'b1;
          if (is_digit) begin
            accum_nxt = (accum_e << 3) + (accum_e << 1) + {12'd0, ch[3:0]};
          end else begin
            point_nxt = 1'b1;
          end
        end else begin
          phase_nxt = PH_IDLE;
          term      = item_vld;
        end
      end
      PH_BODY: begin
        if (fits) begin
          cnt_nxt   = cnt_e + 1'b1;
          found_nxt = 1'b1;
          if (is_digit) begin
            if (!point_e || (dl_e != '0))
              accum_nxt = (accum_e << 3) + (accum_e << 1) + {12'd0, ch[3:0]};
            if (point_e && (dl_e != '0))
              dl_nxt = dl_e - 1'b1;
          end else begin
            point_nxt = 1'b1;
          end
        end else begin
          phase_nxt = PH_IDLE;
          term      = item_vld;
        end
      end
      default: begin
      end
    endcase
  end

  // number handed to the scaler
  assign num.accum       = accum_e;
  assign num.digits_left = dl_e;
  assign num.neg         = neg_e;
  assign num.found       = found_e;
  assign consumed        = found_e ? cnt_e : '0;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      neg_r   <= 1'b0;
      point_r <= 1'b0;
      dl_r    <= '0;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      point_r <= point_nxt;
      dl_r    <= dl_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else if (step_en) begin
      accum_r <= accum_nxt;
    end
  end

endmodule

### rtl/core/dtfp_scale.sv
// ----------------------------------------------------------------------------
// dtfp_scale
// Scales the accumulated value by the missing fraction digits and signs it.
// ----------------------------------------------------------------------------
module dtfp_scale (
  input  dtfp_pkg::num_t                num,
  output logic [dtfp_pkg::VALUE_W-1:0]  value
);
  import dtfp_pkg::*;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   mag;

  // multiply by the power of ten, wrapped
  assign prod = num.accum * pow10(num.digits_left);
  assign mag  = prod[VALUE_W-1:0];

  // sign and zero when nothing was found
  always_comb begin
    if (!num.found)
      value = '0;
    else if (num.neg)
      value = VALUE_W'(~mag + 1'b1);
    else
      value = mag;
  end

endmodule

### rtl/core/decimal_text_to_fixed_point_core.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_core
// Streaming ascii decimal text to fixed-point converter.
// ----------------------------------------------------------------------------
// result: registered when the parser takes the terminating character
// throughput: one character per cycle; the input register stalls only when a
//   terminating character meets a result still waiting in the output register
// reset: synchronous active-low rst_n clears parser state, frac_digits to 0
//   and both valid flags
module decimal_text_to_fixed_point_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,   // frac_digits
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] ch
  input  logic        in_tuser,      // [0] start_req
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // [15:0] value, [23:16] consumed
  output logic        out_tuser      // [0] found
);
  import dtfp_pkg::*;

  logic               s1_valid_r;
  logic [CH_W-1:0]    s1_ch_r;
  logic               s1_start_r;
  logic [FRAC_W-1:0]  frac_r;

  logic               term, out_free, s1_adv;
  num_t               num;
  logic [COUNT_W-1:0] consumed;
  logic [VALUE_W-1:0] value;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic               out_found_r;

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!term || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= '0;
    end else if (cfg_wr_en) begin
      frac_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r    <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  dtfp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s1_adv),
    .item_vld    (s1_valid_r),
    .ch          (s1_ch_r),
    .start       (s1_start_r),
    .frac_digits (frac_r),
    .term        (term),
    .num         (num),
    .consumed    (consumed)
  );

  dtfp_scale u_scale (
    .num   (num),
    .value (value)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && term) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && term) begin
      out_value_r <= value;
      out_cnt_r   <= consumed;
      out_found_r <= num.found;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_value_r};
  assign out_tuser  = out_found_r;

endmodule
